// File: hdl/ssrg_pkg.sv
// ----------------------------------------------------------------------------
// ssrg_pkg
// Types, codes and constants shared by the servo ramp generator modules.
// ----------------------------------------------------------------------------
package ssrg_pkg;

   localparam int NUM_SERVOS_DEF = 6;
   localparam int GROUP_SIZE_DEF = 4;
   localparam int GROUP_LANES    = 4;   // group targets carried by one request
   localparam int MAX_SERVOS     = 16;

   localparam logic [7:0]  ANGLE_FULL = 8'd180;

   localparam logic [7:0]  STEP_SIZE_RST = 8'd5;
   localparam logic [11:0] PULSE_MIN_RST = 12'd150;
   localparam logic [11:0] PULSE_MAX_RST = 12'd600;

   // floor(x / 180) == (x * MAP_RECIP) >> MAP_SHIFT for every x below 2^20
   localparam int          MAP_SHIFT = 28;
   localparam logic [20:0] MAP_RECIP = 21'd1491309;

   localparam logic [7:0] RESET_ANGLES [MAX_SERVOS] = '{
      8'd0, 8'd110, 8'd145, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE = 2'd0,
      CSR_PULSE_MIN = 2'd1,
      CSR_PULSE_MAX = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_GROUP  = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] servo_id;
      logic [7:0] target_angle;
      logic [7:0] group_target_0;
      logic [7:0] group_target_1;
      logic [7:0] group_target_2;
      logic [7:0] group_target_3;
      logic [2:0] group_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  servo_index;
      logic [11:0] pulse;
      logic        ramp_done;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] angle_clamp(input logic [7:0] a);
      return (a > ANGLE_FULL) ? ANGLE_FULL : a;
   endfunction

endpackage

// File: hdl/ssrg_pulse_map.sv
// ----------------------------------------------------------------------------
// ssrg_pulse_map
// Shared angle to pulse mapper: pulse_min + angle*(pulse_max-pulse_min)/180,
// quotient truncated toward zero. Three registered steps per angle.
// ----------------------------------------------------------------------------
module ssrg_pulse_map
   import ssrg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [7:0]  angle,
   input  logic [11:0] pulse_min,
   input  logic [11:0] pulse_max,
   output logic        done,
   output logic [11:0] pulse
);

   logic [2:0]  valid_ff, valid_in;
   logic [7:0]  angle_ff;
   logic [19:0] prod_ff, prod_in;
   logic [11:0] quot_ff, quot_in;
   logic [11:0] pulse_ff, pulse_in;
   logic        span_neg;
   logic [11:0] span_mag;
   logic [40:0] recip_prod;

   // span sign and magnitude; the quotient is taken on the magnitude
   assign span_neg = pulse_max < pulse_min;
   assign span_mag = span_neg ? (pulse_min - pulse_max) : (pulse_max - pulse_min);

   assign prod_in    = 20'(angle_ff) * 20'(span_mag);
   assign recip_prod = 41'(prod_ff) * 41'(MAP_RECIP);
   assign quot_in    = recip_prod[MAP_SHIFT +: 12];
   assign pulse_in   = span_neg ? (pulse_min - quot_ff) : (pulse_min + quot_ff);
   assign valid_in   = {valid_ff[1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         angle_ff <= angle;
      end
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      if (valid_ff[2]) begin
         pulse_ff <= pulse_in;
      end
   end

   assign done  = valid_ff[2];
   assign pulse = pulse_ff;

endmodule

// File: hdl/servo_stepped_ramp_generator_unit.sv
// ----------------------------------------------------------------------------
// servo_stepped_ramp_generator_unit
// Move and move-group requests finish on acceptance. A tick with k servos
// ramping stalls requests until its k results are issued; each pulse passes
// through the one shared three-step mapper, then waits for a free output.
// Synchronous reset: angles return to their power-up values, no ramp active,
// registers to their defaults.
// ----------------------------------------------------------------------------
module servo_stepped_ramp_generator_unit
   import ssrg_pkg::*;
#(
   parameter int NUM_SERVOS = NUM_SERVOS_DEF,
   parameter int GROUP_SIZE = GROUP_SIZE_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [11:0]          csr_wdata
);

   localparam int IDX_W   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int GRP_A   = (GROUP_SIZE < GROUP_LANES) ? GROUP_SIZE : GROUP_LANES;
   localparam int GRP_MAX = (GRP_A < NUM_SERVOS) ? GRP_A : NUM_SERVOS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_MAP,
      ST_LOAD
   } state_type;

   state_type             state_ff, state_in;
   logic [7:0]            step_ff;
   logic [11:0]           pmin_ff, pmax_ff;
   logic [7:0]            cur_ff   [NUM_SERVOS];
   logic [7:0]            start_ff [NUM_SERVOS];
   logic [7:0]            goal_ff  [NUM_SERVOS];
   logic [NUM_SERVOS-1:0] mask_ff, mask_in;
   logic [NUM_SERVOS-1:0] rem_ff, rem_in;
   logic [7:0]            trav_ff, trav_in;
   logic                  done_ff, done_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic                  req_acc, out_free, single_wr, group_wr, fin_wr, load_rsp;
   logic [IDX_W+2:0]      id_wide;
   logic [IDX_W-1:0]      id_idx;
   logic                  id_ok;
   logic [NUM_SERVOS-1:0] id_oh, grp_member, sel_oh;
   logic [7:0]            tgt, cur_at_id;
   logic [7:0]            grp4 [GROUP_LANES];
   logic [7:0]            grp_ext [NUM_SERVOS];
   logic                  grp_any;
   logic [7:0]            step_eff, t_sat;
   logic [8:0]            t_sum;
   logic [7:0]            ramp_len [NUM_SERVOS];
   logic                  fin_all;
   logic [IDX_W-1:0]      sel;
   logic [7:0]            sel_dist, sel_tr, sel_ang;
   logic                  map_start, map_done;
   logic [11:0]           map_pulse;
   logic [IDX_W+2:0]      idx_wide;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---- request decode ------------------------------------------------------
   assign id_wide = {IDX_W'(0), req_data.servo_id};
   assign id_idx  = id_wide[IDX_W-1:0];
   assign id_ok   = 32'(req_data.servo_id) < NUM_SERVOS;
   assign tgt     = angle_clamp(req_data.target_angle);

   assign grp4[0] = req_data.group_target_0;
   assign grp4[1] = req_data.group_target_1;
   assign grp4[2] = req_data.group_target_2;
   assign grp4[3] = req_data.group_target_3;

   for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_grp
      if (g < GRP_MAX) begin : g_lane
         assign grp_ext[g] = angle_clamp(grp4[g]);
      end else begin : g_none
         assign grp_ext[g] = '0;
      end
   end

   always_comb begin
      cur_at_id = '0;
      grp_any   = 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
         id_oh[i]      = id_ok && (id_idx == IDX_W'(i));
         grp_member[i] = (i < GRP_MAX) && (i < 32'(req_data.group_count));
         if (id_oh[i]) begin
            cur_at_id = cur_ff[i];
         end
         if (grp_member[i] && (grp_ext[i] != cur_ff[i])) begin
            grp_any = 1'b1;
         end
      end
   end

   // ---- tick: travel and arrival check --------------------------------------
   assign step_eff = (step_ff == '0) ? 8'd1 : step_ff;
   assign t_sum    = {1'b0, trav_ff} + {1'b0, step_eff};
   assign t_sat    = (t_sum > {1'b0, ANGLE_FULL}) ? ANGLE_FULL : t_sum[7:0];

   always_comb begin
      fin_all = 1'b1;
      for (int i = 0; i < NUM_SERVOS; i++) begin
         ramp_len[i] = (goal_ff[i] >= start_ff[i]) ? (goal_ff[i] - start_ff[i])
                                                  : (start_ff[i] - goal_ff[i]);
         if (mask_ff[i] && (t_sat < ramp_len[i])) begin
            fin_all = 1'b0;
         end
      end
   end

   // ---- next servo of the tick, lowest index first ---------------------------
   always_comb begin
      sel = '0;
      for (int i = NUM_SERVOS - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            sel = IDX_W'(i);
         end
      end
      for (int i = 0; i < NUM_SERVOS; i++) begin
         sel_oh[i] = rem_ff[i] && (sel == IDX_W'(i));
      end
   end

   assign sel_dist = ramp_len[sel];
   assign sel_tr   = (trav_ff < sel_dist) ? trav_ff : sel_dist;
   assign sel_ang  = (goal_ff[sel] >= start_ff[sel]) ? (start_ff[sel] + sel_tr)
                                                      : (start_ff[sel] - sel_tr);
   assign map_start = (state_ff == ST_PICK) && (rem_ff != '0);

   ssrg_pulse_map u_map (
      .clock     (clock),
      .reset     (reset),
      .start     (map_start),
      .angle     (sel_ang),
      .pulse_min (pmin_ff),
      .pulse_max (pmax_ff),
      .done      (map_done),
      .pulse     (map_pulse)
   );

   // ---- sequencer -----------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      rem_in       = rem_ff;
      trav_in      = trav_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      single_wr    = 1'b0;
      group_wr     = 1'b0;
      fin_wr       = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.command)
                  CMD_SINGLE: begin
                     if (mask_ff == '0 && id_ok && tgt != cur_at_id) begin
                        mask_in   = id_oh;
                        trav_in   = '0;
                        single_wr = 1'b1;
                     end
                  end
                  CMD_GROUP: begin
                     if (mask_ff == '0 && grp_any) begin
                        mask_in  = grp_member;
                        trav_in  = '0;
                        group_wr = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (mask_ff != '0) begin
                        trav_in  = t_sat;
                        done_in  = fin_all;
                        rem_in   = mask_ff;
                        state_in = ST_PICK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PICK: begin
            if (rem_ff == '0) begin
               // all results of the tick issued; close the ramp on arrival
               if (done_ff) begin
                  fin_wr  = 1'b1;
                  mask_in = '0;
                  trav_in = '0;
               end
               state_in = ST_IDLE;
            end else begin
               rem_in   = rem_ff & ~sel_oh;
               idx_in   = sel;
               last_in  = (rem_ff & ~sel_oh) == '0;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               load_rsp     = 1'b1;
               state_in     = ST_PICK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         rem_ff       <= '0;
         trav_ff      <= '0;
         done_ff      <= 1'b0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            cur_ff[i] <= RESET_ANGLES[i];
         end
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rem_ff       <= rem_in;
         trav_ff      <= trav_in;
         done_ff      <= done_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            if (fin_wr && mask_ff[i]) begin
               cur_ff[i] <= goal_ff[i];
            end
         end
      end
   end

   // ---- ramp end points and result register ---------------------------------
   assign idx_wide = {3'b000, idx_ff};

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
         if (single_wr && id_oh[i]) begin
            start_ff[i] <= cur_ff[i];
            goal_ff[i]  <= tgt;
         end else if (group_wr && grp_member[i]) begin
            start_ff[i] <= cur_ff[i];
            goal_ff[i]  <= grp_ext[i];
         end
      end
      if (load_rsp) begin
         rsp_data_ff.servo_index <= idx_wide[2:0];
         rsp_data_ff.pulse       <= map_pulse;
         rsp_data_ff.ramp_done   <= done_ff;
         rsp_data_ff.last        <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- control registers ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SIZE_RST;
         pmin_ff <= PULSE_MIN_RST;
         pmax_ff <= PULSE_MAX_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_ff <= csr_wdata[7:0];
            CSR_PULSE_MIN: pmin_ff <= csr_wdata;
            CSR_PULSE_MAX: pmax_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule
